/* rtl/psr_pkg.sv */
// Shared types, codes and helper functions for the power sequencer with reset hold.
// Used by psr_cfg_regs, psr_seq and power_sequencer_with_reset_hold_top.
// No dependencies.
package psr_pkg;

	// Sequencer phases, as reported on run_phase.
	typedef enum logic [2:0] {
		PH_READY          = 3'd0,
		PH_POWER_ON       = 3'd1,
		PH_BOOT           = 3'd2,
		PH_BOOT_FACTORY   = 3'd3,
		PH_PULSE          = 3'd4,
		PH_REBOOT         = 3'd5,
		PH_REBOOT_FACTORY = 3'd6
	} phase_t;

	// Status LED colors.
	typedef enum logic [1:0] {
		LED_RED    = 2'd0,
		LED_YELLOW = 2'd1,
		LED_GREEN  = 2'd2
	} led_t;

	// Steps inside the boot and reboot phases.
	typedef enum logic [1:0] {
		SUB_ENTER      = 2'd0,
		SUB_UART_WAIT  = 2'd1,
		SUB_MCU_WAIT   = 2'd2,
		SUB_READY_WAIT = 2'd3
	} sub_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MCU_SETTLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UART_SETTLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_OFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTORY_PULSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD   = 3'd4;

	// Rail enable bit positions.
	localparam int unsigned RAIL_READY_BIT = 0;
	localparam int unsigned RAIL_FAN_BIT   = 1;
	localparam int unsigned RAIL_MCU_BIT   = 2;
	localparam int unsigned RAIL_UART_BIT  = 3;

	localparam int unsigned MS_W = 16;
	localparam logic [MS_W-1:0] MS_MAX = '1;

	// Sampled pins of one tick, all active low.
	typedef struct packed {
		logic ready_n;
		logic fan_request_n;
		logic reboot_n;
		logic reset_button_n;
	} pins_t;

	// Timing registers.
	typedef struct packed {
		logic [MS_W-1:0] mcu_settle_ms;
		logic [MS_W-1:0] uart_settle_ms;
		logic [MS_W-1:0] reboot_off_ms;
		logic [MS_W-1:0] factory_pulse_ms;
		logic [MS_W-1:0] reset_hold_ms;
	} cfg_t;

	// State reported after each tick.
	typedef struct packed {
		logic [3:0] rails;
		led_t       led;
		phase_t     phase;
	} status_t;

	// Outcome of one reset-button check.
	typedef struct packed {
		logic            held;
		logic [MS_W-1:0] timer;
		logic            fire;
	} hold_t;

	// Saturating millisecond increment.
	function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
		return (v == MS_MAX) ? v : v + 1'b1;
	endfunction

	// One tick of the reset-button hold detector.
	function automatic hold_t hold_step(input logic held, input logic [MS_W-1:0] timer,
			input logic button_n, input logic [MS_W-1:0] hold_ms);
		hold_t r;
		r.held  = held;
		r.timer = timer;
		r.fire  = 1'b0;
		if (held) begin
			if (button_n) begin
				r.held = 1'b0;
			end else begin
				r.timer = sat_inc(timer);
				r.fire  = (r.timer >= hold_ms);
			end
		end else if (!button_n) begin
			r.held  = 1'b1;
			r.timer = '0;
		end
		return r;
	endfunction

endpackage

/* rtl/psr_cfg_regs.sv */
// Timing configuration registers of the power sequencer.
// Depends on psr_pkg for the register indexes and the cfg_t bundle.
module psr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::MS_W-1:0]      cfg_data,
	output psr_pkg::cfg_t                 cfg
);
	import psr_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken; an index past the list is dropped.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register file with documented reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mcu_settle_ms    <= 16'd1000;
			cfg_q.uart_settle_ms   <= 16'd1000;
			cfg_q.reboot_off_ms    <= 16'd100;
			cfg_q.factory_pulse_ms <= 16'd50;
			cfg_q.reset_hold_ms    <= 16'd5000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MCU_SETTLE:    cfg_q.mcu_settle_ms    <= cfg_data;
				CFG_UART_SETTLE:   cfg_q.uart_settle_ms   <= cfg_data;
				CFG_REBOOT_OFF:    cfg_q.reboot_off_ms    <= cfg_data;
				CFG_FACTORY_PULSE: cfg_q.factory_pulse_ms <= cfg_data;
				CFG_RESET_HOLD:    cfg_q.reset_hold_ms    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/psr_seq.sv */
// Sequencer state registers and next-state logic, advanced once per tick.
// Depends on psr_pkg for phases, codes, structs and the hold detector.
module psr_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  psr_pkg::pins_t   pins,
	input  psr_pkg::cfg_t    cfg,
	output psr_pkg::status_t status
);
	import psr_pkg::*;

	phase_t          phase_q, phase_d;
	sub_t            sub_q, sub_d;
	logic [MS_W-1:0] wait_q, wait_d;
	logic            held_q, held_d;
	logic [MS_W-1:0] rtimer_q, rtimer_d;
	logic [MS_W-1:0] pulse_q, pulse_d;
	logic            factory_q, factory_d;
	logic [3:0]      rails_q, rails_d;
	led_t            led_q, led_d;

	// Next state for one tick.
	always_comb begin
		hold_t           hc;
		logic [MS_W-1:0] w;
		logic [MS_W-1:0] p;
		phase_d   = phase_q;
		sub_d     = sub_q;
		wait_d    = wait_q;
		held_d    = held_q;
		rtimer_d  = rtimer_q;
		pulse_d   = pulse_q;
		factory_d = factory_q;
		rails_d   = rails_q;
		led_d     = led_q;
		hc        = hold_step(held_q, rtimer_q, pins.reset_button_n, cfg.reset_hold_ms);
		w         = sat_inc(wait_q);
		p         = sat_inc(pulse_q);
		case (phase_q)
			PH_READY: begin
				led_d = LED_GREEN;
				rails_d[RAIL_READY_BIT] = 1'b1;
				rails_d[RAIL_FAN_BIT]   = !pins.fan_request_n;
				held_d   = hc.held;
				rtimer_d = hc.timer;
				if (hc.fire) begin
					factory_d = 1'b0;
					phase_d   = factory_q ? PH_REBOOT_FACTORY : PH_REBOOT;
					sub_d     = SUB_ENTER;
					held_d    = 1'b0;
					rtimer_d  = '0;
				end else if (!pins.reboot_n) begin
					phase_d  = PH_PULSE;
					sub_d    = SUB_ENTER;
					held_d   = 1'b0;
					rtimer_d = '0;
					pulse_d  = '0;
				end
			end
			PH_BOOT, PH_BOOT_FACTORY: begin
				case (sub_q)
					SUB_ENTER: begin
						led_d  = LED_YELLOW;
						wait_d = '0;
						if (phase_q == PH_BOOT) begin
							rails_d[RAIL_MCU_BIT] = 1'b1;
							sub_d = SUB_MCU_WAIT;
						end else begin
							rails_d[RAIL_UART_BIT] = 1'b1;
							sub_d = SUB_UART_WAIT;
						end
					end
					SUB_UART_WAIT: begin
						wait_d = w;
						if (w >= cfg.uart_settle_ms) begin
							rails_d[RAIL_MCU_BIT] = 1'b1;
							wait_d = '0;
							sub_d  = SUB_MCU_WAIT;
						end
					end
					SUB_MCU_WAIT: begin
						wait_d = w;
						if (w >= cfg.mcu_settle_ms) begin
							sub_d    = SUB_READY_WAIT;
							held_d   = 1'b0;
							rtimer_d = '0;
						end
					end
					default: begin
						// Waiting for the target; the ready pin wins over the button.
						if (!pins.ready_n) begin
							phase_d  = PH_READY;
							sub_d    = SUB_ENTER;
							held_d   = 1'b0;
							rtimer_d = '0;
						end else begin
							held_d   = hc.held;
							rtimer_d = hc.timer;
							if (hc.fire) begin
								factory_d = 1'b0;
								phase_d   = factory_q ? PH_REBOOT_FACTORY : PH_REBOOT;
								sub_d     = SUB_ENTER;
								held_d    = 1'b0;
								rtimer_d  = '0;
							end
						end
					end
				endcase
			end
			PH_PULSE: begin
				pulse_d = p;
				if (pins.reboot_n) begin
					phase_d  = (p >= cfg.factory_pulse_ms) ? PH_REBOOT_FACTORY : PH_REBOOT;
					sub_d    = SUB_ENTER;
					held_d   = 1'b0;
					rtimer_d = '0;
				end
			end
			PH_REBOOT, PH_REBOOT_FACTORY: begin
				if (sub_q == SUB_ENTER) begin
					rails_d = '0;
					if (phase_q == PH_REBOOT_FACTORY) begin
						rails_d[RAIL_UART_BIT] = 1'b1;
					end
					led_d  = LED_RED;
					wait_d = '0;
					sub_d  = SUB_UART_WAIT;
				end else begin
					wait_d = w;
					if (w >= cfg.reboot_off_ms) begin
						if (phase_q == PH_REBOOT_FACTORY) begin
							factory_d = 1'b1;
						end
						phase_d  = PH_POWER_ON;
						sub_d    = SUB_ENTER;
						held_d   = 1'b0;
						rtimer_d = '0;
					end
				end
			end
			default: begin
				// Power-on: consume the one-shot factory flag and pick the boot.
				led_d     = LED_RED;
				factory_d = 1'b0;
				phase_d   = factory_q ? PH_BOOT_FACTORY : PH_BOOT;
				sub_d     = SUB_ENTER;
				held_d    = 1'b0;
				rtimer_d  = '0;
			end
		endcase
	end

	// State registers, which also hold the reported status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_POWER_ON;
			sub_q     <= SUB_ENTER;
			wait_q    <= '0;
			held_q    <= 1'b0;
			rtimer_q  <= '0;
			pulse_q   <= '0;
			factory_q <= 1'b0;
			rails_q   <= '0;
			led_q     <= LED_RED;
		end else if (step) begin
			phase_q   <= phase_d;
			sub_q     <= sub_d;
			wait_q    <= wait_d;
			held_q    <= held_d;
			rtimer_q  <= rtimer_d;
			pulse_q   <= pulse_d;
			factory_q <= factory_d;
			rails_q   <= rails_d;
			led_q     <= led_d;
		end
	end

	assign status.rails = rails_q;
	assign status.led   = led_q;
	assign status.phase = phase_q;

`ifndef SYNTHESIS
	// The factory flag lives only until the next power-on decision.
	assert property (@(posedge clk) disable iff (!arst_n)
		factory_q |-> phase_q == PH_POWER_ON)
		else $error("factory flag set outside power-on");

	// Phases without inner steps keep the step counter at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_READY || phase_q == PH_PULSE || phase_q == PH_POWER_ON)
		|-> sub_q == SUB_ENTER)
		else $error("inner step set in a phase that has none");

	// The ready rail is dropped on the first reboot tick at the latest.
	assert property (@(posedge clk) disable iff (!arst_n)
		rails_q[RAIL_READY_BIT] |-> (phase_q == PH_READY || phase_q == PH_PULSE
		|| ((phase_q == PH_REBOOT || phase_q == PH_REBOOT_FACTORY) && sub_q == SUB_ENTER)))
		else $error("ready rail on outside ready, pulse or reboot entry");
`endif

endmodule

/* rtl/power_sequencer_with_reset_hold_top.sv */
// Top level of the power sequencer with reset hold: stream ports and input register.
// Depends on psr_pkg, psr_cfg_regs and psr_seq.

// Each input word is one millisecond tick of the four sampled active-low pins
// and yields exactly one output word with the rail enables, LED color and phase
// as they stand after that tick. The block takes one word per clock cycle while
// the result port is not stalled; a word passes an input register and then the
// sequencer state register, which also serves as the output register, before its
// result appears on the result port. The state update is a combinational loop
// around that register. The user must write the timing registers through the cfg
// port only while no tick is in flight; the block itself does not enforce it.
module power_sequencer_with_reset_hold_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input ticks: tdata[0] ready_n, [1] fan_request_n, [2] reboot_n,
	// [3] reset_button_n, [7:4] zero.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	// Results: tdata[0] rail_ready, [1] rail_fan, [2] rail_mcu, [3] rail_uart,
	// [5:4] led_color, [8:6] run_phase, [15:9] zero.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::MS_W-1:0]      cfg_data
);
	import psr_pkg::*;

	logic    valid_s1;
	pins_t   pins_s1;
	logic    out_valid_q;
	logic    step;
	cfg_t    cfg;
	status_t status;

	// A registered word moves on when the result slot is free or being emptied.
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pins_s1.ready_n        <= s_tdata[0];
			pins_s1.fan_request_n  <= s_tdata[1];
			pins_s1.reboot_n       <= s_tdata[2];
			pins_s1.reset_button_n <= s_tdata[3];
		end
	end

	// Result word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	psr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pins   (pins_s1),
		.cfg    (cfg),
		.status (status)
	);

	// Pack the result word.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, status.phase, status.led, status.rails};

`ifndef SYNTHESIS
	// A waiting input word only moves into the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(pins_s1))
		else $error("input word lost or changed while stalled");

	// The sequencer state changes only on a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(status))
		else $error("sequencer state changed without a tick");

	// A result slot is emptied only by a taken word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(m_tready))
		else $error("result word dropped");
`endif

endmodule
